[rtl/nsag_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the nearest-neighbour scaler address generator.
// No dependencies; imported by every module of the block.
package nsag_pkg;

    // Field and internal widths
    localparam int DIM_W           = 13;  // configuration registers and internal positions
    localparam int ERR_W           = 15;  // signed Bresenham error terms
    localparam int OUT_W           = 12;  // column and row result fields
    localparam int ADDR_W          = 24;  // source address result field
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_DIM_DEFAULT = 4096;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH   = 3'd0,
        REG_SRC_HEIGHT  = 3'd1,
        REG_DEST_WIDTH  = 3'd2,
        REG_DEST_HEIGHT = 3'd3,
        REG_ROW_STRIDE  = 3'd4
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VADD,
        ST_VSUB,
        ST_HADD,
        ST_HSUB,
        ST_EMIT
    } state_t;

    // Effective (clamped) dimensions and the raw stride
    typedef struct packed {
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
        logic [DIM_W-1:0] dst_w;
        logic [DIM_W-1:0] dst_h;
        logic [DIM_W-1:0] stride;
    } dims_t;

    // Sequencer to datapath
    typedef struct packed {
        logic start;      // load frame-start values
        logic step_en;    // commit the shared adder result
        logic step_vert;  // adder works on the vertical error
        logic step_sub;   // subtract destination size and advance the position
        logic emit;       // load the output register and advance the raster
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic res_pos;    // adder result above zero
        logic dcol_zero;  // next pixel opens a destination row
        logic out_range;  // raster position outside the current frame
        logic out_free;   // output register can take an item
    } stat_t;

endpackage

[rtl/nearest_scaler_address_gen.sv]
`timescale 1ns / 1ps
// Nearest-neighbour scaler address generator, top level. Uses nsag_pkg, nsag_cfg,
// nsag_ctrl and nsag_dp. Per item: a vertical error pass on the first pixel of a destination
// row or a frame restart, then a horizontal pass, then an emit step that waits for a free
// output register; the passes run one error step per cycle.
// The next item is taken while the finished one waits in the output register.
// Reset (aresetn, synchronous, active low) sets the config registers to 1; first item restarts.
module nearest_scaler_address_gen
    import nsag_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_src_col,
    output logic [OUT_W-1:0]     m_src_row,
    output logic [ADDR_W-1:0]    m_src_address,
    output logic [OUT_W-1:0]     m_dest_col,
    output logic [OUT_W-1:0]     m_dest_row,
    output logic                 m_row_end,
    output logic                 m_frame_end
);

    dims_t dims;
    ctrl_t ctrl;
    stat_t stat;
    logic  restart_pending;

    nsag_cfg #(
        .MAX_DIM(MAX_DIM)
    ) u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .restart_clr     (ctrl.start),
        .dims            (dims),
        .restart_pending (restart_pending)
    );

    nsag_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_restart       (s_restart),
        .restart_pending (restart_pending),
        .stat            (stat),
        .s_ready         (s_ready),
        .ctrl            (ctrl)
    );

    nsag_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dims          (dims),
        .ctrl          (ctrl),
        .stat          (stat),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_src_col     (m_src_col),
        .m_src_row     (m_src_row),
        .m_src_address (m_src_address),
        .m_dest_col    (m_dest_col),
        .m_dest_row    (m_dest_row),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end)
    );

    // an item is never written over a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> (!m_valid || m_ready))
        else $error("output register overwritten");

    // the last pixel of a frame also closes its row
    a_frame_end_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_row_end)
        else $error("frame end without row end");

    // one item at a time: the sequencer is busy after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready straight after accept");

    // a result is loaded only by the sequencer's emit step
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctrl.emit))
        else $error("result without emit");

endmodule

[rtl/nsag_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers, dimension clamping and the pending frame restart.
// Depends on nsag_pkg.
module nsag_cfg
    import nsag_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 restart_clr,
    output dims_t                dims,
    output logic                 restart_pending
);

    localparam int CMP_W = 17;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] MAX_DIM_T = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg, stride_reg;
    logic [DIM_W-1:0] src_w_next, src_h_next, dst_w_next, dst_h_next, stride_next;
    logic             pending_reg, pending_next;
    logic             wr_hit;

    // zero reads as one, anything above the limit reads as the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (CMP_W'(v) > MAX_DIM_C) begin
            r = MAX_DIM_T;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // register write decode
    always_comb begin
        src_w_next  = src_w_reg;
        src_h_next  = src_h_reg;
        dst_w_next  = dst_w_reg;
        dst_h_next  = dst_h_reg;
        stride_next = stride_reg;
        wr_hit      = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SRC_WIDTH:   begin src_w_next  = cfg_data; wr_hit = 1'b1; end
                REG_SRC_HEIGHT:  begin src_h_next  = cfg_data; wr_hit = 1'b1; end
                REG_DEST_WIDTH:  begin dst_w_next  = cfg_data; wr_hit = 1'b1; end
                REG_DEST_HEIGHT: begin dst_h_next  = cfg_data; wr_hit = 1'b1; end
                REG_ROW_STRIDE:  begin stride_next = cfg_data; wr_hit = 1'b1; end
                default:         wr_hit = 1'b0;
            endcase
        end
    end

    // a write to one of the five registers restarts the frame on the next item
    always_comb begin
        if (wr_hit) begin
            pending_next = 1'b1;
        end else if (restart_clr) begin
            pending_next = 1'b0;
        end else begin
            pending_next = pending_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg   <= DIM_W'(1);
            src_h_reg   <= DIM_W'(1);
            dst_w_reg   <= DIM_W'(1);
            dst_h_reg   <= DIM_W'(1);
            stride_reg  <= DIM_W'(1);
            pending_reg <= 1'b1;
        end else begin
            src_w_reg   <= src_w_next;
            src_h_reg   <= src_h_next;
            dst_w_reg   <= dst_w_next;
            dst_h_reg   <= dst_h_next;
            stride_reg  <= stride_next;
            pending_reg <= pending_next;
        end
    end

    assign dims.src_w     = eff_dim(src_w_reg);
    assign dims.src_h     = eff_dim(src_h_reg);
    assign dims.dst_w     = eff_dim(dst_w_reg);
    assign dims.dst_h     = eff_dim(dst_h_reg);
    assign dims.stride    = stride_reg;
    assign restart_pending = pending_reg;

endmodule

[rtl/nsag_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer: steps the shared error adder through the vertical and horizontal passes.
// Depends on nsag_pkg.
module nsag_ctrl
    import nsag_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_restart,
    input  logic  restart_pending,
    input  stat_t stat,
    output logic  s_ready,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;
    logic   start_cond;

    assign start_cond = s_restart || restart_pending || stat.out_range;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (start_cond || stat.dcol_zero) ? ST_VADD : ST_HADD;
                end
            end
            ST_VADD, ST_VSUB: state_next = stat.res_pos ? ST_VSUB : ST_HADD;
            ST_HADD, ST_HSUB: state_next = stat.res_pos ? ST_HSUB : ST_EMIT;
            ST_EMIT:          state_next = stat.out_free ? ST_IDLE : ST_EMIT;
            default:          state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = 1'b0;
        ctrl.start     = 1'b0;
        ctrl.step_en   = 1'b0;
        ctrl.step_vert = 1'b0;
        ctrl.step_sub  = 1'b0;
        ctrl.emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                ctrl.start = s_valid && start_cond;
            end
            ST_VADD: begin
                ctrl.step_en   = 1'b1;
                ctrl.step_vert = 1'b1;
            end
            ST_VSUB: begin
                ctrl.step_en   = 1'b1;
                ctrl.step_vert = 1'b1;
                ctrl.step_sub  = 1'b1;
            end
            ST_HADD: ctrl.step_en = 1'b1;
            ST_HSUB: begin
                ctrl.step_en  = 1'b1;
                ctrl.step_sub = 1'b1;
            end
            ST_EMIT: ctrl.emit = stat.out_free;
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/nsag_dp.sv]
`timescale 1ns / 1ps
// Datapath: error and position registers, the shared add/subtract unit,
// the address multiplier and the output register. Depends on nsag_pkg.
module nsag_dp
    import nsag_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dims_t             dims,
    input  ctrl_t             ctrl,
    output stat_t             stat,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [OUT_W-1:0]  m_src_col,
    output logic [OUT_W-1:0]  m_src_row,
    output logic [ADDR_W-1:0] m_src_address,
    output logic [OUT_W-1:0]  m_dest_col,
    output logic [OUT_W-1:0]  m_dest_row,
    output logic              m_row_end,
    output logic              m_frame_end
);

    logic [ERR_W-1:0] herr_reg, herr_next, verr_reg, verr_next;
    logic [DIM_W-1:0] scol_reg, scol_next, srow_reg, srow_next;
    logic [DIM_W-1:0] dcol_reg, dcol_next, drow_reg, drow_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_src_col_reg, m_src_row_reg, m_dest_col_reg, m_dest_row_reg;
    logic [ADDR_W-1:0] m_src_address_reg;
    logic              m_row_end_reg, m_frame_end_reg;

    logic [ERR_W-1:0]   h_init, v_init;
    logic [ERR_W-1:0]   alu_a, alu_b, alu_res;
    logic [DIM_W-1:0]   alu_dim;
    logic               rend, fend;
    logic [2*DIM_W-1:0] row_base;
    logic [ADDR_W-1:0]  addr;

    // frame and row start error values: minus half the source minus the destination
    assign h_init = ERR_W'(0) - ERR_W'(dims.src_w >> 1) - ERR_W'(dims.dst_w);
    assign v_init = ERR_W'(0) - ERR_W'(dims.src_h >> 1) - ERR_W'(dims.dst_h);

    // shared error adder
    always_comb begin
        if (ctrl.step_vert) begin
            alu_a   = verr_reg;
            alu_dim = ctrl.step_sub ? dims.dst_h : dims.src_h;
        end else begin
            alu_a   = herr_reg;
            alu_dim = ctrl.step_sub ? dims.dst_w : dims.src_w;
        end
        alu_b   = ERR_W'(alu_dim);
        alu_res = ctrl.step_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // raster position flags and source address
    assign rend     = (dcol_reg == DIM_W'(dims.dst_w - DIM_W'(1)));
    assign fend     = rend && (drow_reg == DIM_W'(dims.dst_h - DIM_W'(1)));
    assign row_base = srow_reg * dims.stride;
    assign addr     = ADDR_W'(row_base) + ADDR_W'(scol_reg);

    assign stat.res_pos   = !alu_res[ERR_W-1] && (alu_res != '0);
    assign stat.dcol_zero = (dcol_reg == '0);
    assign stat.out_range = (dcol_reg >= dims.dst_w) || (drow_reg >= dims.dst_h);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // state update
    always_comb begin
        herr_next = herr_reg;
        verr_next = verr_reg;
        scol_next = scol_reg;
        srow_next = srow_reg;
        dcol_next = dcol_reg;
        drow_next = drow_reg;
        priority if (ctrl.start || (ctrl.emit && fend)) begin
            herr_next = h_init;
            verr_next = v_init;
            scol_next = '0;
            srow_next = '0;
            dcol_next = '0;
            drow_next = '0;
        end else if (ctrl.emit && rend) begin
            herr_next = h_init;
            scol_next = '0;
            dcol_next = '0;
            drow_next = DIM_W'(drow_reg + DIM_W'(1));
        end else if (ctrl.emit) begin
            dcol_next = DIM_W'(dcol_reg + DIM_W'(1));
        end else if (ctrl.step_en && ctrl.step_vert) begin
            verr_next = alu_res;
            if (ctrl.step_sub) begin
                srow_next = DIM_W'(srow_reg + DIM_W'(1));
            end
        end else if (ctrl.step_en) begin
            herr_next = alu_res;
            if (ctrl.step_sub) begin
                scol_next = DIM_W'(scol_reg + DIM_W'(1));
            end
        end else begin
            herr_next = herr_reg;
        end
    end

    // output item handshake
    always_comb begin
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            herr_reg    <= '0;
            verr_reg    <= '0;
            scol_reg    <= '0;
            srow_reg    <= '0;
            dcol_reg    <= '0;
            drow_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            herr_reg    <= herr_next;
            verr_reg    <= verr_next;
            scol_reg    <= scol_next;
            srow_reg    <= srow_next;
            dcol_reg    <= dcol_next;
            drow_reg    <= drow_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_src_col_reg     <= OUT_W'(scol_reg);
            m_src_row_reg     <= OUT_W'(srow_reg);
            m_src_address_reg <= addr;
            m_dest_col_reg    <= OUT_W'(dcol_reg);
            m_dest_row_reg    <= OUT_W'(drow_reg);
            m_row_end_reg     <= rend;
            m_frame_end_reg   <= fend;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_src_col     = m_src_col_reg;
    assign m_src_row     = m_src_row_reg;
    assign m_src_address = m_src_address_reg;
    assign m_dest_col    = m_dest_col_reg;
    assign m_dest_row    = m_dest_row_reg;
    assign m_row_end     = m_row_end_reg;
    assign m_frame_end   = m_frame_end_reg;

endmodule

[tb/nearest_scaler_address_gen_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for nearest_scaler_address_gen: directed geometries, then random
// geometries and restarts under random handshake gaps. Depends on nsag_pkg and the RTL only.
module nearest_scaler_address_gen_tb;
    import nsag_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_DIM       = MAX_DIM_DEFAULT;
    localparam int DIM_CODE_MAX  = (1 << DIM_W) - 1;
    localparam int RANDOM_ITEMS  = 900;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 50000;
    localparam int PHASE_BUDGET  = 40000;

    // One result item as seen on the m_ side
    typedef struct packed {
        logic [OUT_W-1:0]  src_col;
        logic [OUT_W-1:0]  src_row;
        logic [ADDR_W-1:0] src_address;
        logic [OUT_W-1:0]  dest_col;
        logic [OUT_W-1:0]  dest_row;
        logic              row_end;
        logic              frame_end;
    } pixel_map_t;

    // Raster walker with Bresenham error stepping; holds the expected pixel mappings
    class pixel_map_scoreboard;
        logic [DIM_W-1:0] sw_reg, sh_reg, dw_reg, dh_reg, stride_reg;
        int               h_err, v_err;
        int unsigned      col_pos, row_pos, dcol_pos, drow_pos;
        pixel_map_t       expected_maps [$];
        int               failures;

        function new();
            sw_reg     = 1;
            sh_reg     = 1;
            dw_reg     = 1;
            dh_reg     = 1;
            stride_reg = 1;
            failures   = 0;
            restart_frame();
        endfunction

        // zero reads as one, anything above the maximum as the maximum
        static function int unsigned clamp_dim(logic [DIM_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_DIM)
                return MAX_DIM;
            return 32'(v);
        endfunction

        function void restart_row();
            h_err   = -int'(clamp_dim(sw_reg) >> 1) - int'(clamp_dim(dw_reg));
            col_pos = 0;
        endfunction

        function void restart_frame();
            restart_row();
            v_err    = -int'(clamp_dim(sh_reg) >> 1) - int'(clamp_dim(dh_reg));
            row_pos  = 0;
            dcol_pos = 0;
            drow_pos = 0;
        endfunction

        // gain the source size, then advance while the error is above zero
        function void error_step(inout int err, inout int unsigned pos,
                                 input int unsigned src, input int unsigned dst);
            int steps;
            err += int'(src);
            if (err > 0) begin
                steps = (err + int'(dst) - 1) / int'(dst);
                pos  += steps;
                err  -= steps * int'(dst);
            end
        endfunction

        // register write; an unknown index is ignored and does not restart
        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                REG_SRC_WIDTH:   sw_reg = data;
                REG_SRC_HEIGHT:  sh_reg = data;
                REG_DEST_WIDTH:  dw_reg = data;
                REG_DEST_HEIGHT: dh_reg = data;
                REG_ROW_STRIDE:  stride_reg = data;
                default:         return;
            endcase
            restart_frame();
        endfunction

        // accepted input item: work out the pixel it produces
        function void predict_pixel(logic restart);
            int unsigned     sw, sh, dw, dh;
            logic            rend, fend;
            logic [63:0]     addr;
            pixel_map_t      px;
            sw = clamp_dim(sw_reg);
            sh = clamp_dim(sh_reg);
            dw = clamp_dim(dw_reg);
            dh = clamp_dim(dh_reg);
            if (restart)
                restart_frame();
            if (dcol_pos >= dw || drow_pos >= dh)
                restart_frame();
            if (dcol_pos == 0)
                error_step(v_err, row_pos, sh, dh);
            error_step(h_err, col_pos, sw, dw);

            rend = (dcol_pos + 1 == dw);
            fend = rend && (drow_pos + 1 == dh);
            addr = 64'(row_pos) * 64'(stride_reg) + 64'(col_pos);

            px.src_col     = col_pos[OUT_W-1:0];
            px.src_row     = row_pos[OUT_W-1:0];
            px.src_address = addr[ADDR_W-1:0];
            px.dest_col    = dcol_pos[OUT_W-1:0];
            px.dest_row    = drow_pos[OUT_W-1:0];
            px.row_end     = rend;
            px.frame_end   = fend;
            expected_maps.push_back(px);

            if (fend) begin
                restart_frame();
            end else if (rend) begin
                restart_row();
                dcol_pos = 0;
                drow_pos++;
            end else begin
                dcol_pos++;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // accepted result item: compare with the oldest expectation
        function void check_pixel(pixel_map_t got);
            pixel_map_t want;
            if (expected_maps.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, got dest (%0d,%0d)",
                         $time, got.dest_col, got.dest_row);
                return;
            end
            want = expected_maps.pop_front();
            compare_field("src_col", want.src_col, got.src_col);
            compare_field("src_row", want.src_row, got.src_row);
            compare_field("src_address", want.src_address, got.src_address);
            compare_field("dest_col", want.dest_col, got.dest_col);
            compare_field("dest_row", want.dest_row, got.dest_row);
            compare_field("row_end", want.row_end, got.row_end);
            compare_field("frame_end", want.frame_end, got.frame_end);
        endfunction

        function int pending();
            return expected_maps.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_restart;
    logic                 m_valid;
    logic                 m_ready;
    logic [OUT_W-1:0]     m_src_col;
    logic [OUT_W-1:0]     m_src_row;
    logic [ADDR_W-1:0]    m_src_address;
    logic [OUT_W-1:0]     m_dest_col;
    logic [OUT_W-1:0]     m_dest_row;
    logic                 m_row_end;
    logic                 m_frame_end;

    pixel_map_scoreboard maps;
    bit                  no_gaps      = 1'b0;
    bit                  hold_off_req = 1'b0;
    int                  idle_cycles  = 0;

    nearest_scaler_address_gen uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_src_col     (m_src_col),
        .m_src_row     (m_src_row),
        .m_src_address (m_src_address),
        .m_dest_col    (m_dest_col),
        .m_dest_row    (m_dest_row),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // mostly short gaps, a few long ones; none at all in quiet phases
    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // mostly small sizes, with zero and out-of-range codes mixed in
    function automatic logic [DIM_W-1:0] pick_dim();
        int r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return DIM_W'($urandom_range(MAX_DIM + 1, DIM_CODE_MAX));
        if (r < 22)
            return DIM_W'(MAX_DIM);
        if (r < 35)
            return DIM_W'($urandom_range(25, 300));
        return DIM_W'($urandom_range(1, 24));
    endfunction

    // monitor: configuration writes, accepted inputs and results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                maps.apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                maps.predict_pixel(s_restart);
            if (m_valid && m_ready)
                maps.check_pixel('{m_src_col, m_src_row, m_src_address, m_dest_col,
                                   m_dest_row, m_row_end, m_frame_end});
        end
    end

    // watchdog: too long without any accepted item or write
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                int stall;
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // offer one item and wait for it to be taken
    task automatic send_item(input logic restart);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // stop offering and wait until every expected pixel has come back;
    // the first edge lets the monitor note the last accepted item
    task automatic close_phase();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (maps.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // program all five registers, optionally followed by a write to an unused index
    task automatic set_geometry(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                                input logic [DIM_W-1:0] stride, input bit stray);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SRC_WIDTH;
        cfg_data  <= sw;
        @(posedge aclk);
        cfg_index <= REG_SRC_HEIGHT;
        cfg_data  <= sh;
        @(posedge aclk);
        cfg_index <= REG_DEST_WIDTH;
        cfg_data  <= dw;
        @(posedge aclk);
        cfg_index <= REG_DEST_HEIGHT;
        cfg_data  <= dh;
        @(posedge aclk);
        cfg_index <= REG_ROW_STRIDE;
        cfg_data  <= stride;
        @(posedge aclk);
        if (stray) begin
            cfg_index <= CFG_IDX_W'(REG_ROW_STRIDE + 1 + $urandom_range(0, 2));
            cfg_data  <= DIM_W'($urandom_range(0, DIM_CODE_MAX));
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int          random_sent;
        int          n_items;
        int unsigned cost;
        logic [DIM_W-1:0] sw, sh, dw, dh, stride;

        maps = new();
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_SRC_WIDTH;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_restart <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry, one pixel per frame, with and without restart
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        close_phase();

        // largest codes, clamped; deep rows overflow the 24-bit address
        set_geometry(DIM_W'(DIM_CODE_MAX), DIM_W'(DIM_CODE_MAX), 1, 2,
                     DIM_W'(DIM_CODE_MAX), 1'b0);
        repeat (3) send_item(1'b0);
        close_phase();

        // zero sizes read as one, zero stride
        set_geometry(0, 0, 0, 0, 0, 1'b1);
        send_item(1'b0);
        send_item(1'b1);
        close_phase();

        // equal sizes give the identity mapping; restart mid-frame
        set_geometry(5, 3, 5, 3, DIM_W'(MAX_DIM), 1'b0);
        for (int i = 0; i < 8; i++)
            send_item(i == 4);
        close_phase();

        // strong upscale to the largest destination
        set_geometry(3, 2, DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), 1, 1'b0);
        repeat (4) send_item(1'b0);
        close_phase();

        // strong horizontal downscale, single source row
        set_geometry(DIM_W'(MAX_DIM), 1, 7, 1, 13, 1'b1);
        repeat (5) send_item(1'b0);
        close_phase();

        // long receiver hold-off while the sender keeps offering
        random_sent = 0;
        set_geometry(DIM_W'($urandom_range(1, 24)), DIM_W'($urandom_range(1, 24)),
                     DIM_W'($urandom_range(1, 24)), DIM_W'($urandom_range(1, 24)),
                     DIM_W'($urandom_range(1, 64)), 1'b0);
        no_gaps      = 1'b1;
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item($urandom_range(0, 24) == 0);
        close_phase();
        random_sent += 40;

        // random geometries; item count per phase kept within an estimated cost budget
        while (random_sent < RANDOM_ITEMS) begin
            sw      = pick_dim();
            sh      = pick_dim();
            dw      = pick_dim();
            dh      = pick_dim();
            stride  = ($urandom_range(0, 4) == 0) ? DIM_W'($urandom_range(0, 16))
                                                  : DIM_W'($urandom_range(0, DIM_CODE_MAX));
            no_gaps = ($urandom_range(0, 3) == 0);
            cost    = pixel_map_scoreboard::clamp_dim(sw) / pixel_map_scoreboard::clamp_dim(dw)
                    + pixel_map_scoreboard::clamp_dim(sh) / pixel_map_scoreboard::clamp_dim(dh)
                    + 8;
            n_items = $urandom_range(15, 70);
            if (n_items > PHASE_BUDGET / cost)
                n_items = PHASE_BUDGET / cost;
            if (n_items < 1)
                n_items = 1;
            set_geometry(sw, sh, dw, dh, stride, $urandom_range(0, 4) == 0);
            for (int i = 0; i < n_items; i++)
                send_item($urandom_range(0, 24) == 0);
            close_phase();
            random_sent += n_items;
        end

        repeat (20) @(posedge aclk);
        if (maps.failures == 0 && maps.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/nsag_pkg.sv
rtl/nsag_cfg.sv
rtl/nsag_ctrl.sv
rtl/nsag_dp.sv
rtl/nearest_scaler_address_gen.sv
tb/nearest_scaler_address_gen_tb.sv
